// File: sv/integer_to_radix_ascii_core_assert.svh
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core assertion macros
// Shared concurrent assertion forms, clocked on clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_RADIX_ASCII_CORE_ASSERT_SVH
`define INTEGER_TO_RADIX_ASCII_CORE_ASSERT_SVH

// same-cycle implication
`define ITRA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define ITRA_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/itra_pkg.sv
// ----------------------------------------------------------------------------
// itra_pkg
// Types, constants and helpers for the integer to radix ASCII converter.
// ----------------------------------------------------------------------------
`default_nettype none

package itra_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int RADIX_W     = 6;
	localparam int CHAR_W      = 8;
	localparam int CNT_W       = $clog2(VALUE_WIDTH + 1);
	localparam int IDX_W       = $clog2(VALUE_WIDTH);

	localparam logic [RADIX_W-1:0] RADIX_MIN = 6'd2;
	localparam logic [RADIX_W-1:0] RADIX_MAX = 6'd36;
	localparam logic [RADIX_W-1:0] RADIX_DEC = 6'd10;

	localparam logic [CHAR_W-1:0] CHAR_MINUS   = 8'h2D;
	localparam logic [CHAR_W-1:0] CHAR_ZERO    = 8'h30;
	localparam logic [CHAR_W-1:0] CHAR_UPPER_A = 8'h41;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] value;
		logic [RADIX_W-1:0]     radix;
		logic                   unsigned_decimal;
	} req_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} rsp_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_DIV,
		ST_EMIT
	} state_t;

	function automatic logic [CHAR_W-1:0] digit_char(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] d8;
		d8 = {{(CHAR_W-RADIX_W){1'b0}}, d};
		if (d < RADIX_DEC) begin
			digit_char = CHAR_ZERO + d8;
		end else begin
			digit_char = CHAR_UPPER_A + d8 - {{(CHAR_W-RADIX_W){1'b0}}, RADIX_DEC};
		end
	endfunction

endpackage

`default_nettype wire

// File: sv/integer_to_radix_ascii_core.sv
// ----------------------------------------------------------------------------
// integer_to_radix_ascii_core
// Converts an integer to ASCII digits in radix 2..36, most significant first.
// ----------------------------------------------------------------------------
// Usage:
//   req channel (req_valid/req_stall/req) takes value, radix and the
//   unsigned_decimal flag. rsp channel (rsp_valid/rsp_stall/rsp) returns the
//   characters of a request one at a time, with last set on the final digit.
//   Radix ten with unsigned_decimal low treats value as signed and prefixes
//   '-' if negative. Digits come from a bit-serial restoring divider, one
//   quotient bit per cycle, and are emitted once the last digit is divided.
//   One request is worked at a time; req_stall is high from acceptance until
//   the last character is loaded into the output register, so the next
//   request is taken while that character still waits. rsp_stall holds the
//   output register and pauses emission; the divider is not affected. Reset
//   clears the control state and drops any pending output.
// ----------------------------------------------------------------------------
`default_nettype none

`include "integer_to_radix_ascii_core_assert.svh"

module integer_to_radix_ascii_core (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          req_valid,
	output logic               req_stall,
	input  wire itra_pkg::req_t req,
	output logic               rsp_valid,
	input  wire logic          rsp_stall,
	output itra_pkg::rsp_t     rsp
);

	localparam int W     = itra_pkg::VALUE_WIDTH;
	localparam int RW    = itra_pkg::RADIX_W;
	localparam int CNT_W = itra_pkg::CNT_W;
	localparam int IDX_W = itra_pkg::IDX_W;

	itra_pkg::state_t state_q, state_nx;

	logic [W-1:0]     quot_q;
	logic [RW-1:0]    rem_q;
	logic [RW-1:0]    rad_q;
	logic [IDX_W-1:0] bit_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] idx_q;
	logic             sign_pend_q;
	logic             rsp_valid_q;
	itra_pkg::rsp_t   rsp_q;
	logic [RW-1:0]    store_q [W];

	logic [RW-1:0]    rad_in;
	logic             neg_in;
	logic [W-1:0]     mag_in;
	logic [RW:0]      rem_sh;
	logic             q_bit;
	logic [RW:0]      rem_dif;
	logic [W-1:0]     quot_nx;
	logic             bit_last;
	logic             div_done;
	logic [CNT_W-1:0] idx_m1;
	logic             emit_load;
	logic             emit_end;
	logic             accept;

	// request decode
	always_comb begin
		if (req.radix < itra_pkg::RADIX_MIN) begin
			rad_in = itra_pkg::RADIX_MIN;
		end else if (req.radix > itra_pkg::RADIX_MAX) begin
			rad_in = itra_pkg::RADIX_MAX;
		end else begin
			rad_in = req.radix;
		end
		neg_in = (rad_in == itra_pkg::RADIX_DEC) && !req.unsigned_decimal && req.value[W-1];
		mag_in = neg_in ? (~req.value + {{(W-1){1'b0}}, 1'b1}) : req.value;
	end

	// one restoring division step
	always_comb begin
		rem_sh   = {rem_q, quot_q[W-1]};
		q_bit    = (rem_sh >= {1'b0, rad_q});
		rem_dif  = q_bit ? (rem_sh - {1'b0, rad_q}) : rem_sh;
		quot_nx  = {quot_q[W-2:0], q_bit};
		bit_last = (bit_q == IDX_W'(W - 1));
		div_done = bit_last && ((quot_nx == '0) || (cnt_q == CNT_W'(W - 1)));
		idx_m1   = idx_q - CNT_W'(1);
	end

	// next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			itra_pkg::ST_IDLE: begin
				if (req_valid) begin
					state_nx = itra_pkg::ST_DIV;
				end
			end
			itra_pkg::ST_DIV: begin
				if (div_done) begin
					state_nx = itra_pkg::ST_EMIT;
				end
			end
			itra_pkg::ST_EMIT: begin
				if (emit_end) begin
					state_nx = itra_pkg::ST_IDLE;
				end
			end
			default: state_nx = itra_pkg::ST_IDLE;
		endcase
	end

	// state outputs
	always_comb begin
		req_stall = 1'b1;
		emit_load = 1'b0;
		unique case (state_q)
			itra_pkg::ST_IDLE: req_stall = 1'b0;
			itra_pkg::ST_DIV:  req_stall = 1'b1;
			itra_pkg::ST_EMIT: emit_load = !rsp_valid_q || !rsp_stall;
			default:           req_stall = 1'b1;
		endcase
		accept   = req_valid && !req_stall;
		emit_end = emit_load && !sign_pend_q && (idx_q == CNT_W'(1));
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= itra_pkg::ST_IDLE;
			bit_q       <= '0;
			cnt_q       <= '0;
			idx_q       <= '0;
			sign_pend_q <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_nx;
			if (accept) begin
				bit_q       <= '0;
				cnt_q       <= '0;
				sign_pend_q <= neg_in;
			end else if (state_q == itra_pkg::ST_DIV) begin
				bit_q <= bit_last ? '0 : bit_q + IDX_W'(1);
				if (bit_last) begin
					cnt_q <= cnt_q + CNT_W'(1);
					if (div_done) begin
						idx_q <= cnt_q + CNT_W'(1);
					end
				end
			end
			if (emit_load) begin
				rsp_valid_q <= 1'b1;
				if (sign_pend_q) begin
					sign_pend_q <= 1'b0;
				end else begin
					idx_q <= idx_m1;
				end
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// datapath and digit store
	always_ff @(posedge clk) begin
		if (accept) begin
			quot_q <= mag_in;
			rem_q  <= '0;
			rad_q  <= rad_in;
		end else if (state_q == itra_pkg::ST_DIV) begin
			if (bit_last) begin
				store_q[cnt_q[IDX_W-1:0]] <= rem_dif[RW-1:0];
				rem_q                     <= '0;
			end else begin
				rem_q <= rem_dif[RW-1:0];
			end
			quot_q <= quot_nx;
		end
		if (emit_load) begin
			if (sign_pend_q) begin
				rsp_q.character <= itra_pkg::CHAR_MINUS;
				rsp_q.last      <= 1'b0;
			end else begin
				rsp_q.character <= itra_pkg::digit_char(store_q[idx_m1[IDX_W-1:0]]);
				rsp_q.last      <= (idx_q == CNT_W'(1));
			end
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ITRA_ASSERT_NOW(a_rem_below_radix, state_q == itra_pkg::ST_DIV, rem_q < rad_q, "remainder not below radix")
	`ITRA_ASSERT_NOW(a_radix_range, state_q == itra_pkg::ST_DIV, (rad_q >= itra_pkg::RADIX_MIN) && (rad_q <= itra_pkg::RADIX_MAX), "radix out of range")
	`ITRA_ASSERT_NOW(a_emit_index, state_q == itra_pkg::ST_EMIT, (idx_q != '0) && (idx_q <= CNT_W'(W)), "emit index out of range")
	`ITRA_ASSERT_NXT(a_done_to_emit, (state_q == itra_pkg::ST_DIV) && div_done, (state_q == itra_pkg::ST_EMIT) && (idx_q == cnt_q), "digit count lost on entry to emit")

endmodule

`default_nettype wire
